// ----- rtl/core/csbm_pkg.sv -----
// shared types and constants of the clock sweep buffer manager
package csbm_pkg;

    // fixed widths of the slot index and slot count buses between cells and of the config register
    localparam int IDX_W = 8;
    localparam int CNT_W = 9;
    localparam int CFG_W = 5;

    // result status codes
    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_MISS       = 2'd1;
    localparam logic [1:0] STAT_ALL_PINNED = 2'd2;

    // input command codes
    localparam logic CMD_REQUEST = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // configuration register index
    localparam logic [2:0] ADDR_SLOTS_IN_USE = 3'd0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_SWEEP
    } state_t;

    typedef enum logic [2:0] {
        CELL_NONE,
        CELL_HIT,
        CELL_TAKE,
        CELL_DEC,
        CELL_UNPIN
    } cell_op_t;

    // command broadcast to every cell
    typedef struct packed {
        cell_op_t          op;
        logic [IDX_W-1:0]  target;
        logic [CNT_W-1:0]  n;
        logic [7:0]        key;
        logic [31:0]       page;
    } cell_ctrl_t;

    // what one cell shows to the sweep logic
    typedef struct packed {
        logic        valid;
        logic        pinned;
        logic        usage_zero;
        logic [7:0]  table_key;
        logic [31:0] page;
    } cell_stat_t;

endpackage

// ----- rtl/core/csbm_cell.sv -----
// one buffer slot: directory entry, pin, usage count and the lookup chain links
module csbm_cell #(
    parameter int IDX       = 0,
    parameter int UW        = 4,
    parameter int USAGE_MAX = 15
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  csbm_pkg::cell_ctrl_t     ctrl,
    input  logic                     hit_in,
    input  logic [csbm_pkg::IDX_W-1:0] idx_in,
    input  logic                     free_in,
    output logic                     hit_out,
    output logic [csbm_pkg::IDX_W-1:0] idx_out,
    output logic                     free_out,
    output csbm_pkg::cell_stat_t     stat
);
    import csbm_pkg::*;

    logic          valid_reg;
    logic          pinned_reg;
    logic [UW-1:0] usage_reg;
    logic [7:0]    table_reg;
    logic [31:0]   page_reg;
    logic          in_use;
    logic          match;
    logic          sel;

    // lookup and free-slot chain
    assign in_use   = ctrl.n > CNT_W'(IDX);
    assign match    = valid_reg && in_use && (table_reg == ctrl.key) && (page_reg == ctrl.page);
    assign hit_out  = hit_in || match;
    assign idx_out  = (!hit_in && match) ? IDX_W'(IDX) : idx_in;
    assign free_out = free_in || (in_use && !pinned_reg);
    assign sel      = ctrl.target == IDX_W'(IDX);

    assign stat.valid      = valid_reg;
    assign stat.pinned     = pinned_reg;
    assign stat.usage_zero = usage_reg == '0;
    assign stat.table_key  = table_reg;
    assign stat.page       = page_reg;

    // control state of the slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            pinned_reg <= 1'b0;
            usage_reg  <= '0;
        end else if (sel) begin
            case (ctrl.op)
                CELL_HIT: begin
                    pinned_reg <= 1'b1;
                    if (usage_reg < UW'(USAGE_MAX)) usage_reg <= usage_reg + 1'b1;
                end
                CELL_TAKE: begin
                    valid_reg  <= 1'b1;
                    pinned_reg <= 1'b1;
                    usage_reg  <= UW'(1);
                end
                CELL_DEC: begin
                    if (usage_reg != '0) usage_reg <= usage_reg - 1'b1;
                end
                CELL_UNPIN: begin
                    pinned_reg <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // directory entry
    always_ff @(posedge aclk) begin
        if (sel && ctrl.op == CELL_TAKE) begin
            table_reg <= ctrl.key;
            page_reg  <= ctrl.page;
        end
    end

endmodule

// ----- rtl/core/clock_sweep_buffer_manager_top.sv -----
// Clock sweep buffer manager: row of slot cells plus sweep controller.
// Hit, release and all-pinned results are decided in the look state and registered once the
// output is free; a miss sweeps the hand, decrementing usage, to an unpinned slot of usage 0.
// One item at a time: the next item is accepted once the controller is idle again.
// Reset (aresetn low, synchronous) clears valid, pin, usage, hand and output valid;
// slots_in_use resets to 16.
module clock_sweep_buffer_manager_top #(
    parameter int SLOTS     = 16,
    parameter int USAGE_MAX = 15
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input: tuser = command
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: table_key[7:0], page_no[39:8], release_slot[43:40], zero [47:44]
    input  logic [47:0] s_tdata,
    input  logic [0:0]  s_tuser,
    // result: tuser = status[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: slot[3:0], evicted_valid[4], evicted_table[12:5], evicted_page[44:13], zero [47:45]
    output logic [47:0] m_tdata,
    output logic [1:0]  m_tuser,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import csbm_pkg::*;

    localparam int HW = $clog2(SLOTS);
    localparam int UW = $clog2(USAGE_MAX + 1);

    state_t            state_reg, state_next;
    logic [CFG_W-1:0]  cfg_reg;
    logic [HW-1:0]     hand_reg, hand_next;
    logic              cmd_reg;
    logic [7:0]        key_reg;
    logic [31:0]       page_reg;
    logic [3:0]        rel_reg;
    logic              m_valid_reg;
    logic [47:0]       m_data_reg, m_data_next;
    logic [1:0]        m_user_reg, m_user_next;
    logic              emit;
    logic              out_free;
    logic [CNT_W-1:0]  n;
    logic [CNT_W-1:0]  hand_inc;
    cell_ctrl_t        ctrl;
    cell_stat_t        cur;

    logic              hit_c  [SLOTS+1];
    logic [IDX_W-1:0]  idx_c  [SLOTS+1];
    logic              free_c [SLOTS+1];
    cell_stat_t        stat_a [SLOTS];

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_SLOTS_IN_USE) ? 32'(cfg_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_W'(16);
        end else if (psel && penable && pwrite && paddr == ADDR_SLOTS_IN_USE) begin
            cfg_reg <= pwdata[CFG_W-1:0];
        end
    end

    // effective slot count, clamped to 1..SLOTS
    always_comb begin
        if (cfg_reg == '0) n = CNT_W'(1);
        else if (int'(cfg_reg) > SLOTS) n = CNT_W'(SLOTS);
        else n = CNT_W'(cfg_reg);
    end

    // row of slot cells
    assign hit_c[0]  = 1'b0;
    assign idx_c[0]  = '0;
    assign free_c[0] = 1'b0;

    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        csbm_cell #(.IDX(i), .UW(UW), .USAGE_MAX(USAGE_MAX)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .hit_in   (hit_c[i]),
            .idx_in   (idx_c[i]),
            .free_in  (free_c[i]),
            .hit_out  (hit_c[i+1]),
            .idx_out  (idx_c[i+1]),
            .free_out (free_c[i+1]),
            .stat     (stat_a[i])
        );
    end

    assign cur      = stat_a[hand_reg];
    assign out_free = !m_valid_reg || m_tready;
    assign hand_inc = CNT_W'(hand_reg) + 1'b1;
    assign s_tready = state_reg == ST_IDLE;

    // state, hand and captured item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            hand_reg  <= '0;
        end else begin
            state_reg <= state_next;
            hand_reg  <= hand_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg  <= s_tuser[0];
            key_reg  <= s_tdata[7:0];
            page_reg <= s_tdata[39:8];
            rel_reg  <= s_tdata[43:40];
        end
    end

    // next state, cell commands and result
    always_comb begin
        state_next  = state_reg;
        hand_next   = hand_reg;
        emit        = 1'b0;
        m_data_next = '0;
        m_user_next = STAT_OK;
        ctrl.op     = CELL_NONE;
        ctrl.target = IDX_W'(hand_reg);
        ctrl.n      = n;
        ctrl.key    = key_reg;
        ctrl.page   = page_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_LOOK;
            end
            ST_LOOK: begin
                if (cmd_reg == CMD_RELEASE) begin
                    if (out_free) begin
                        ctrl.op          = CELL_UNPIN;
                        ctrl.target      = IDX_W'(rel_reg);
                        m_data_next[3:0] = rel_reg;
                        emit             = 1'b1;
                        state_next       = ST_IDLE;
                    end
                end else if (hit_c[SLOTS]) begin
                    if (out_free) begin
                        ctrl.op          = CELL_HIT;
                        ctrl.target      = idx_c[SLOTS];
                        m_data_next[3:0] = idx_c[SLOTS][3:0];
                        emit             = 1'b1;
                        state_next       = ST_IDLE;
                    end
                end else if (!free_c[SLOTS]) begin
                    if (out_free) begin
                        m_user_next = STAT_ALL_PINNED;
                        emit        = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end else begin
                    if (CNT_W'(hand_reg) >= n) hand_next = '0;
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (!cur.pinned && cur.usage_zero) begin
                    if (out_free) begin
                        ctrl.op          = CELL_TAKE;
                        m_user_next      = STAT_MISS;
                        m_data_next[3:0] = 4'(hand_reg);
                        m_data_next[4]   = cur.valid;
                        if (cur.valid) begin
                            m_data_next[12:5]  = cur.table_key;
                            m_data_next[44:13] = cur.page;
                        end
                        hand_next  = (hand_inc == n) ? '0 : hand_inc[HW-1:0];
                        emit       = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else begin
                    ctrl.op   = CELL_DEC;
                    hand_next = (hand_inc == n) ? '0 : hand_inc[HW-1:0];
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ----- rtl/core/csbm_checker.sv -----
// port-level checks of the clock sweep buffer manager and their binding
module csbm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import csbm_pkg::*;

    // one item at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in work");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // status is one of the three codes
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser != 2'd3)
        else $error("bad status code");

    // refused miss carries no slot and no eviction
    a_pinned: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STAT_ALL_PINNED |-> m_tdata == 48'd0)
        else $error("all-pinned result not zero");

    // hits and releases never report an eviction
    a_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STAT_OK |-> m_tdata[47:4] == 44'd0)
        else $error("eviction reported on hit or release");

endmodule

bind clock_sweep_buffer_manager_top csbm_checker u_csbm_checker (.*);

// ----- tb/sv/clock_sweep_buffer_manager_top_tb.sv -----
// testbench for the clock sweep buffer manager: directed table, random traffic, self-checking
`timescale 1ns / 100ps

module clock_sweep_buffer_manager_top_tb;
    import csbm_pkg::*;

    localparam int NSLOTS   = 16;
    localparam int USE_TOP  = 15;
    localparam int IDLE_MAX = 8000;

    typedef struct packed {
        logic [3:0]  slot;
        logic [1:0]  status;
        logic        ev_valid;
        logic [7:0]  ev_table;
        logic [31:0] ev_page;
    } result_t;

    typedef struct {
        bit          is_cfg;
        logic [4:0]  cfg_val;
        logic        cmd;
        logic [7:0]  key;
        logic [31:0] page;
        logic [3:0]  rel;
        bit          typed;
        result_t     want;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // shadow copy of the slot directory
    logic        pool_valid [NSLOTS];
    logic [7:0]  pool_key   [NSLOTS];
    logic [31:0] pool_page  [NSLOTS];
    logic        pool_pin   [NSLOTS];
    int          pool_usage [NSLOTS];
    int          sweep_hand;
    logic [4:0]  active_cfg;

    result_t pending_results[$];
    row_t    rows[$];
    int      errors = 0;
    int      sent = 0;
    int      n_hit = 0, n_miss = 0, n_full = 0, n_rel = 0;
    int      idle_cycles = 0;
    bit      send_burst = 0, recv_burst = 0;

    always #1 aclk = ~aclk;

    clock_sweep_buffer_manager_top dut (.*);

    // expected outcome of one transaction, updating the shadow directory
    function automatic result_t lookup_page(logic cmd, logic [7:0] key, logic [31:0] page,
                                            logic [3:0] rel);
        result_t r;
        int n;
        int h;
        bit any_free;
        r = '0;
        any_free = 0;
        n = int'(active_cfg);
        if (n < 1) n = 1;
        if (n > NSLOTS) n = NSLOTS;
        if (cmd == CMD_RELEASE) begin
            pool_pin[rel] = 1'b0;
            r.slot = rel;
            r.status = STAT_OK;
            return r;
        end
        for (int i = 0; i < n; i++) begin
            if (pool_valid[i] && pool_key[i] == key && pool_page[i] == page) begin
                if (pool_usage[i] < USE_TOP) pool_usage[i]++;
                pool_pin[i] = 1'b1;
                r.slot = 4'(i);
                r.status = STAT_OK;
                return r;
            end
        end
        for (int i = 0; i < n; i++)
            if (!pool_pin[i]) any_free = 1;
        if (!any_free) begin
            r.status = STAT_ALL_PINNED;
            return r;
        end
        if (sweep_hand >= n) sweep_hand = 0;
        forever begin
            h = sweep_hand;
            if (!pool_pin[h] && pool_usage[h] == 0) begin
                r.slot = 4'(h);
                r.status = STAT_MISS;
                if (pool_valid[h]) begin
                    r.ev_valid = 1'b1;
                    r.ev_table = pool_key[h];
                    r.ev_page = pool_page[h];
                end
                pool_valid[h] = 1'b1;
                pool_key[h] = key;
                pool_page[h] = page;
                pool_pin[h] = 1'b1;
                pool_usage[h] = 1;
                sweep_hand = (h + 1) % n;
                return r;
            end
            if (pool_usage[h] > 0) pool_usage[h]--;
            sweep_hand = (h + 1) % n;
        end
    endfunction

    // register write, only while the block is idle
    task automatic write_slots_in_use(logic [4:0] v);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_SLOTS_IN_USE;
        pwdata <= {27'd0, v};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        active_cfg = v;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    // one input transaction; typed rows supply their own expectation
    task automatic send_item(logic cmd, logic [7:0] key, logic [31:0] page, logic [3:0] rel,
                             bit typed, result_t want);
        int gap;
        result_t r;
        if ($urandom_range(0, 39) == 0) send_burst = ~send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {4'd0, rel, page, key};
        do @(posedge aclk); while (!s_tready);
        r = lookup_page(cmd, key, page, rel);
        pending_results.push_back(typed ? want : r);
        sent++;
    endtask

    // random transaction, mostly drawn from a small key set so hits and sweeps occur
    task automatic send_random();
        logic cmd;
        logic [7:0] key;
        logic [31:0] page;
        logic [3:0] rel;
        cmd = ($urandom_range(0, 99) < 40) ? CMD_RELEASE : CMD_REQUEST;
        rel = 4'($urandom);
        if ($urandom_range(0, 9) < 8) begin
            key = 8'($urandom_range(0, 3));
            page = ($urandom_range(0, 7) == 0) ? 32'hffff_ffff : $urandom_range(0, 5);
        end else begin
            key = 8'($urandom);
            page = $urandom;
        end
        send_item(cmd, key, page, rel, 1'b0, '0);
    endtask

    // result side: random stalls, compare each transaction with the oldest expectation
    initial begin
        result_t want;
        int stall;
        @(posedge aresetn);
        forever begin
            if ($urandom_range(0, 39) == 0) recv_burst = ~recv_burst;
            stall = recv_burst ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            if (pending_results.size() == 0) begin
                $error("result with no expectation: tdata %h tuser %h", m_tdata, m_tuser);
                errors++;
            end else begin
                want = pending_results.pop_front();
                case (want.status)
                    STAT_MISS: n_miss++;
                    STAT_ALL_PINNED: n_full++;
                    default: n_hit++;
                endcase
                if (m_tdata[3:0] !== want.slot) begin
                    $error("slot: expected %0d actual %0d", want.slot, m_tdata[3:0]);
                    errors++;
                end
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d actual %0d", want.status, m_tuser);
                    errors++;
                end
                if (m_tdata[4] !== want.ev_valid) begin
                    $error("evicted_valid: expected %0d actual %0d", want.ev_valid, m_tdata[4]);
                    errors++;
                end
                if (m_tdata[12:5] !== want.ev_table) begin
                    $error("evicted_table: expected %h actual %h", want.ev_table, m_tdata[12:5]);
                    errors++;
                end
                if (m_tdata[44:13] !== want.ev_page) begin
                    $error("evicted_page: expected %h actual %h", want.ev_page, m_tdata[44:13]);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_MAX) begin
            $display("timeout: no transaction for %0d cycles", IDLE_MAX);
            $display("** clock_sweep_buffer_manager_top: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // main sequence
    initial begin
        logic [4:0] phase_cfg[$];
        result_t none;
        none = '0;
        for (int i = 0; i < NSLOTS; i++) begin
            pool_valid[i] = '0; pool_key[i] = '0; pool_page[i] = '0;
            pool_pin[i] = '0; pool_usage[i] = 0;
        end
        sweep_hand = 0;
        active_cfg = 5'd16;

        // directed rows
        rows.push_back('{0, 0, CMD_REQUEST, 8'h00, 32'h0, 4'h0, 1,
                         '{4'd0, STAT_MISS, 1'b0, 8'h0, 32'h0}});
        rows.push_back('{0, 0, CMD_REQUEST, 8'h00, 32'h0, 4'h0, 1,
                         '{4'd0, STAT_OK, 1'b0, 8'h0, 32'h0}});
        rows.push_back('{0, 0, CMD_REQUEST, 8'hff, 32'hffff_ffff, 4'hf, 1,
                         '{4'd1, STAT_MISS, 1'b0, 8'h0, 32'h0}});
        rows.push_back('{0, 0, CMD_RELEASE, 8'hff, 32'hffff_ffff, 4'h0, 1,
                         '{4'd0, STAT_OK, 1'b0, 8'h0, 32'h0}});
        // release of a slot that was never pinned
        rows.push_back('{0, 0, CMD_RELEASE, 8'h00, 32'h0, 4'hf, 1,
                         '{4'd15, STAT_OK, 1'b0, 8'h0, 32'h0}});
        rows.push_back('{0, 0, CMD_REQUEST, 8'hff, 32'hffff_ffff, 4'h0, 1,
                         '{4'd1, STAT_OK, 1'b0, 8'h0, 32'h0}});
        rows.push_back('{0, 0, CMD_REQUEST, 8'ha5, 32'h5a5a_a5a5, 4'ha, 0, none});
        rows.push_back('{0, 0, CMD_REQUEST, 8'h5a, 32'ha5a5_5a5a, 4'h5, 0, none});
        // shrink to one slot: hand restarts at zero, sweep evicts slot 0
        rows.push_back('{1, 5'd1, 0, 0, 0, 0, 0, none});
        rows.push_back('{0, 0, CMD_REQUEST, 8'h01, 32'h5, 4'h0, 0, none});
        rows.push_back('{0, 0, CMD_REQUEST, 8'h02, 32'h6, 4'h0, 1,
                         '{4'd0, STAT_ALL_PINNED, 1'b0, 8'h0, 32'h0}});
        rows.push_back('{0, 0, CMD_RELEASE, 8'h00, 32'h0, 4'h0, 1,
                         '{4'd0, STAT_OK, 1'b0, 8'h0, 32'h0}});
        // zero acts as one slot
        rows.push_back('{1, 5'd0, 0, 0, 0, 0, 0, none});
        rows.push_back('{0, 0, CMD_REQUEST, 8'h02, 32'h6, 4'h0, 0, none});
        rows.push_back('{0, 0, CMD_REQUEST, 8'h03, 32'h7, 4'h0, 1,
                         '{4'd0, STAT_ALL_PINNED, 1'b0, 8'h0, 32'h0}});
        // above the slot count acts as all slots; an old entry outside use may duplicate
        rows.push_back('{1, 5'd31, 0, 0, 0, 0, 0, none});
        rows.push_back('{0, 0, CMD_REQUEST, 8'h01, 32'h5, 4'h0, 0, none});
        rows.push_back('{0, 0, CMD_REQUEST, 8'hff, 32'hffff_ffff, 4'h0, 0, none});
        rows.push_back('{0, 0, CMD_REQUEST, 8'h00, 32'h0, 4'h0, 0, none});
        rows.push_back('{1, 5'd17, 0, 0, 0, 0, 0, none});
        rows.push_back('{0, 0, CMD_REQUEST, 8'h00, 32'h8000_0000, 4'h0, 0, none});

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) begin
            if (rows[i].is_cfg) begin
                s_tvalid <= 1'b0;
                wait_drained();
                write_slots_in_use(rows[i].cfg_val);
            end else begin
                send_item(rows[i].cmd, rows[i].key, rows[i].page, rows[i].rel,
                          rows[i].typed, rows[i].want);
            end
        end

        // random phases across several register settings, extremes included
        phase_cfg = '{5'd16, 5'd1, 5'd2, 5'd0, 5'd31, 5'd3, 5'd17, 5'd8,
                      5'($urandom_range(1, 16)), 5'd16};
        foreach (phase_cfg[p]) begin
            s_tvalid <= 1'b0;
            wait_drained();
            write_slots_in_use(phase_cfg[p]);
            repeat (83) send_random();
        end
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (20) @(posedge aclk);

        $display("covered %0d transactions over %0d slot settings: %0d hits/releases, %0d misses,",
                 sent, phase_cfg.size() + 4, n_hit, n_miss);
        $display("%0d refusals with every slot pinned", n_full);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("** clock_sweep_buffer_manager_top: PASSED **");
        end else begin
            $display("** clock_sweep_buffer_manager_top: FAILED **");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/csbm_pkg.sv
rtl/core/csbm_cell.sv
rtl/core/clock_sweep_buffer_manager_top.sv
rtl/core/csbm_checker.sv
tb/sv/clock_sweep_buffer_manager_top_tb.sv
